// ----- sv/wapt_pkg.sv -----
package wapt_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int MEAN_W    = 24;
    localparam int COUNT_W   = 9;
    localparam int LEVEL_W   = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W    = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = 1'b1;

    // register reset values
    localparam logic signed [SAMPLE_W-1:0] LOW_BOUND_RST  = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] HIGH_BOUND_RST = 16'sd32767;

    // op codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // level of a sample at or above the top of the range
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd256;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] newest;
        logic signed [MEAN_W-1:0]   mean_q8;
        logic signed [SAMPLE_W-1:0] peak;
        logic [COUNT_W-1:0]         count;
        logic [LEVEL_W-1:0]         level;
        logic                       above_mark;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic scan_init;
        logic scan_rd;
        logic lvl_take;
        logic mean_start;
        logic publish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_last;
        logic div_busy;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- sv/window_average_peak_tracker_core.sv -----
// Sliding window tracker over the last DEPTH signed 16-bit samples. Each input beat
// (push or clear) yields one result beat with the newest sample, the window mean
// in Q8 truncated toward zero, the window maximum, the fill count, the newest
// sample's level in the low/high bound range (0..256) and an 80% mark flag; an
// empty window gives all zeros. Items are handled one at a time. The shared
// restoring divider is 24 + clog2(DEPTH) bits wide (32 at DEPTH 256). The
// window is scanned with one read per cycle from the sample memory's single
// read port; the divider runs the level divide during that scan and the mean
// divide after it. A new input beat is taken while the previous result still
// waits in the output register. The bound registers are written through the
// cfg port; the user must write them only while idle, as the block itself
// does not enforce it.
module window_average_peak_tracker_core import wapt_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer
    wapt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // store, accumulators, divider and output register
    wapt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

// ----- sv/wapt_ram.sv -----
module wapt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/wapt_div.sv -----
module wapt_div #(
    parameter int NUMW = 32,
    parameter int DENW = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            busy,
    output logic [NUMW-1:0] quot
);

    localparam int SW = (NUMW > 1) ? $clog2(NUMW) : 1;

    logic            busy_reg;
    logic [SW-1:0]   step_reg;
    logic [DENW:0]   rem_reg;
    logic [DENW:0]   rem_next;
    logic [NUMW-1:0] quo_reg;
    logic [DENW-1:0] den_reg;
    logic [DENW:0]   shifted;
    logic            fits;

    // restoring step: one quotient bit per cycle
    always_comb begin
        shifted  = {rem_reg[DENW-1:0], quo_reg[NUMW-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= SW'(NUMW - 1);
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUMW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

// ----- sv/wapt_datapath.sv -----
module wapt_datapath import wapt_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  in_item_t             s_data,
    input  ctrl_cmd_t            cmd,
    output ctrl_sts_t            sts,
    input  logic                 m_ready,
    output logic                 m_valid,
    output out_item_t            m_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int SUMW = SAMPLE_W + AW;
    localparam int NUMW = SUMW + FRAC_W;
    localparam int DENW = (CNTW > SAMPLE_W) ? CNTW : SAMPLE_W;
    localparam int SPW  = SAMPLE_W + 1;
    localparam int MKW  = SPW + 3;

    logic signed [SAMPLE_W-1:0] low_reg;
    logic signed [SAMPLE_W-1:0] high_reg;
    logic signed [SAMPLE_W-1:0] newest_reg;
    logic signed [SAMPLE_W-1:0] peak_reg;
    logic [AW-1:0]              wp_reg;
    logic [AW-1:0]              wp_next;
    logic [AW-1:0]              rd_ptr_reg;
    logic [AW-1:0]              rd_ptr_next;
    logic [CNTW-1:0]            cnt_reg;
    logic [CNTW-1:0]            remain_reg;
    logic signed [SUMW-1:0]     sum_reg;
    logic                       acc_en_reg;
    logic                       first_reg;
    logic [LEVEL_W-1:0]         level_reg;
    logic                       m_valid_reg;
    out_item_t                  m_data_reg;

    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_sample;
    logic                       ram_we;
    logic [CNTW:0]              wp_ext;
    logic [CNTW:0]              cnt_ext;
    logic [CNTW:0]              start_ext;

    logic signed [SPW-1:0]      span_raw;
    logic signed [SPW-1:0]      span_pos;
    logic signed [SPW-1:0]      offset;
    logic                       lvl_zero;
    logic                       lvl_full;
    logic signed [MKW-1:0]      off_m;
    logic signed [MKW-1:0]      off5;
    logic signed [MKW-1:0]      span4;
    logic                       above;

    logic                       sum_neg;
    logic [SUMW-1:0]            sum_mag;
    logic [NUMW-1:0]            div_num;
    logic [DENW-1:0]            div_den;
    logic                       div_start;
    logic                       div_busy;
    logic [NUMW-1:0]            div_quot;
    logic [MEAN_W-1:0]          mean_mag;
    logic [MEAN_W-1:0]          mean_val;
    logic [LEVEL_W-1:0]         level_val;

    // ring store
    assign ram_we    = cmd.take && (s_data.op == OP_PUSH);
    assign rd_sample = $signed(ram_rdata);

    wapt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (s_data.sample),
        .re    (cmd.scan_rd),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // pointer wrap and oldest entry
    always_comb begin
        wp_next     = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        wp_ext      = (CNTW + 1)'(wp_reg);
        cnt_ext     = (CNTW + 1)'(cnt_reg);
        start_ext   = (wp_ext >= cnt_ext) ? (wp_ext - cnt_ext)
                                          : (wp_ext + (CNTW + 1)'(DEPTH) - cnt_ext);
    end

    // range span, offset and mark
    always_comb begin
        span_raw = {high_reg[SAMPLE_W-1], high_reg} - {low_reg[SAMPLE_W-1], low_reg};
        span_pos = (span_raw[SPW-1] || (span_raw == '0)) ? SPW'(1) : span_raw;
        offset   = {newest_reg[SAMPLE_W-1], newest_reg} - {low_reg[SAMPLE_W-1], low_reg};
        lvl_zero = offset[SPW-1] || (offset == '0);
        lvl_full = offset >= span_pos;
        off_m    = {{3{offset[SPW-1]}}, offset};
        off5     = (off_m <<< 2) + off_m;
        span4    = {{3{span_pos[SPW-1]}}, span_pos} <<< 2;
        above    = off5 >= span4;
    end

    // divider operands: level first, then mean
    always_comb begin
        sum_neg   = sum_reg[SUMW-1];
        sum_mag   = sum_neg ? $unsigned(-sum_reg) : $unsigned(sum_reg);
        div_start = cmd.scan_init || cmd.mean_start;
        if (cmd.mean_start) begin
            div_num = {sum_mag, {FRAC_W{1'b0}}};
            div_den = DENW'(cnt_reg);
        end else begin
            div_num = NUMW'({offset[SAMPLE_W-1:0], {FRAC_W{1'b0}}});
            div_den = DENW'(span_pos[SAMPLE_W-1:0]);
        end
        mean_mag  = div_quot[MEAN_W-1:0];
        mean_val  = sum_neg ? (~mean_mag + 1'b1) : mean_mag;
        if (lvl_zero) begin
            level_val = '0;
        end else if (lvl_full) begin
            level_val = LEVEL_FULL;
        end else begin
            level_val = LEVEL_W'(div_quot[FRAC_W-1:0]);
        end
    end

    wapt_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= LOW_BOUND_RST;
            high_reg <= HIGH_BOUND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOW_BOUND:  low_reg  <= $signed(cfg_wdata[SAMPLE_W-1:0]);
                REG_HIGH_BOUND: high_reg <= $signed(cfg_wdata[SAMPLE_W-1:0]);
                default: ;
            endcase
        end
    end

    // window pointer and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            cnt_reg <= '0;
        end else if (cmd.take) begin
            if (s_data.op == OP_CLEAR) begin
                wp_reg  <= '0;
                cnt_reg <= '0;
            end else begin
                wp_reg <= wp_next;
                if (cnt_reg != CNTW'(DEPTH)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // newest sample
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            newest_reg <= s_data.sample;
        end
    end

    // scan address and remaining entries
    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            rd_ptr_reg <= AW'(start_ext);
            remain_reg <= cnt_reg;
        end else if (cmd.scan_rd) begin
            rd_ptr_reg <= rd_ptr_next;
            remain_reg <= remain_reg - 1'b1;
        end
    end

    // read data lands in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.scan_rd;
        end
    end

    // running sum and maximum
    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            sum_reg   <= '0;
            first_reg <= 1'b1;
        end else if (acc_en_reg) begin
            sum_reg   <= sum_reg + {{(SUMW - SAMPLE_W){rd_sample[SAMPLE_W-1]}}, rd_sample};
            first_reg <= 1'b0;
            if (first_reg || (rd_sample > peak_reg)) begin
                peak_reg <= rd_sample;
            end
        end
    end

    // level capture
    always_ff @(posedge aclk) begin
        if (cmd.lvl_take) begin
            level_reg <= level_val;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            if (cnt_reg == '0) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg.newest     <= newest_reg;
                m_data_reg.mean_q8    <= $signed(mean_val);
                m_data_reg.peak       <= peak_reg;
                m_data_reg.count      <= COUNT_W'(cnt_reg);
                m_data_reg.level      <= level_reg;
                m_data_reg.above_mark <= above;
            end
        end
    end

    // status
    assign sts.empty     = (cnt_reg == '0);
    assign sts.scan_last = (remain_reg == CNTW'(1));
    assign sts.div_busy  = div_busy;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(DEPTH))
        else $error("fill count beyond window depth");

    a_scan_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |-> remain_reg != '0)
        else $error("scan read past the filled window");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish && (cnt_reg == '0) |=> m_valid_reg && (m_data_reg == '0))
        else $error("empty window result not all zero");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish && (cnt_reg != '0) |-> level_reg <= LEVEL_FULL)
        else $error("level beyond full scale");

endmodule

// ----- sv/wapt_ctrl.sv -----
module wapt_ctrl import wapt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_SCAN_END,
        ST_LVL_WAIT,
        ST_MEAN_WAIT,
        ST_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (sts.empty) begin
                    state_next = ST_PUBLISH;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_LVL_WAIT;
            end
            ST_LVL_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.lvl_take   = 1'b1;
                    cmd.mean_start = 1'b1;
                    state_next     = ST_MEAN_WAIT;
                end
            end
            ST_MEAN_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH: begin
                if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
